// File: hdl/bfa_pkg.sv
// Shared types and constants of the bitmap frame allocator.
package bfa_pkg;

    localparam int COUNT_W  = 13;
    localparam int INDEX_W  = 12;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 1;

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESERVE = 2'd2;

    localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STS_NONE_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] STS_RANGE     = 2'd2;

    localparam logic [APB_AW-1:0] REG_FRAME_COUNT = 1'd0;

    localparam logic [COUNT_W-1:0] FRAME_COUNT_RST = 13'd4096;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WORD,
        ST_MODIFY
    } t_state;

endpackage

// File: hdl/bfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/bitmap_frame_allocator.sv
// Top level of the first-fit bitmap frame allocator.
//
//  channel   | ports                                        | transfer
//  ----------+----------------------------------------------+--------------------------------
//  command   | start, busy, i_operation, i_frame_index      | edge with start high, busy low
//  result    | o_done, o_frame_result, o_status             | one cycle, o_done high
//  config    | psel, penable, pwrite, paddr, pwdata, prdata | access phase, pready high
//
// Free and reserve pass through the modify state; an out-of-range or unused operation
// is answered from idle. Alloc scans the summary, one summary word per cycle, then sets
// the lowest free bit of the first free word, or reports none free when all are full.
// Bitmap and per-word full summary sit in two RAMs; each update is read, modify, write.
// After reset a clearing pass writes ones to every bitmap and summary word, busy high.
// The receiver cannot stall: each result shows on o_done for exactly one cycle.
module bitmap_frame_allocator
    import bfa_pkg::*;
#(
    parameter int MAX_FRAMES = 4096,
    parameter int WORD_BITS  = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     i_operation,
    input  logic [INDEX_W-1:0]  i_frame_index,
    output logic                o_done,
    output logic [INDEX_W-1:0]  o_frame_result,
    output logic [STATUS_W-1:0] o_status,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    localparam int LB        = $clog2(WORD_BITS + 1) - 1;
    localparam int LANE_W    = 2 ** LB;
    localparam int WORD_CNT  = (MAX_FRAMES + LANE_W - 1) / LANE_W;
    localparam int SUM_DEPTH = (WORD_CNT + LANE_W - 1) / LANE_W;
    localparam int WORD_AW   = (WORD_CNT > 1) ? $clog2(WORD_CNT) : 1;
    localparam int SUM_AW    = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;
    localparam int CW_A      = (WORD_AW + LB + 1 > COUNT_W) ? WORD_AW + LB + 1 : COUNT_W;
    localparam int CMP_W     = (2 * LB + SUM_AW + 1 > CW_A) ? 2 * LB + SUM_AW + 1 : CW_A;

    t_state                r_state, n_state;
    logic [WORD_AW-1:0]    r_clr_cnt, n_clr_cnt;
    logic [OP_W-1:0]       r_op, n_op;
    logic [INDEX_W-1:0]    r_idx, n_idx;
    logic [WORD_AW-1:0]    r_word, n_word;
    logic [LB-1:0]         r_bit, n_bit;
    logic [SUM_AW-1:0]     r_sum_idx, n_sum_idx;
    logic [LB-1:0]         r_sbit, n_sbit;
    logic [LANE_W-1:0]     r_sum_word, n_sum_word;
    logic [COUNT_W-1:0]    r_frame_count;
    logic                  r_done, n_done;
    logic [INDEX_W-1:0]    r_result, n_result;
    logic [STATUS_W-1:0]   r_status, n_status;

    logic                  bm_we, sm_we;
    logic [WORD_AW-1:0]    bm_waddr, bm_raddr;
    logic [SUM_AW-1:0]     sm_waddr, sm_raddr;
    logic [LANE_W-1:0]     bm_wdata, bm_rdata, sm_wdata, sm_rdata;

    logic [CMP_W-1:0]      count_eff, fc_ext, idx_ext, scan_word_ext, frame_ext;
    logic                  accept, in_range, is_upd, sum_found, scan_last, clr_last, cfg_wr;
    logic [LB-1:0]         sum_lz, word_lz;
    logic [LANE_W-1:0]     bit_mask, sbit_mask, new_word;

    function automatic logic [LB-1:0] low_zero(input logic [LANE_W-1:0] v);
        logic [LB-1:0] pos;
        pos = '0;
        for (int i = LANE_W - 1; i >= 0; i--) begin
            if (!v[i]) begin
                pos = LB'(i);
            end
        end
        return pos;
    endfunction

    bfa_ram #(.WIDTH(LANE_W), .DEPTH(WORD_CNT)) u_bitmap_ram (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    bfa_ram #(.WIDTH(LANE_W), .DEPTH(SUM_DEPTH)) u_summary_ram (
        .i_clk   (i_clk),
        .i_we    (sm_we),
        .i_waddr (sm_waddr),
        .i_wdata (sm_wdata),
        .i_raddr (sm_raddr),
        .o_rdata (sm_rdata)
    );

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr == REG_FRAME_COUNT) ? APB_DW'(r_frame_count) : '0;

    assign fc_ext    = CMP_W'(r_frame_count);
    assign count_eff = (fc_ext > CMP_W'(MAX_FRAMES)) ? CMP_W'(MAX_FRAMES) : fc_ext;
    assign idx_ext   = CMP_W'(i_frame_index);
    assign in_range  = idx_ext < count_eff;
    assign is_upd    = (i_operation == OP_FREE) || (i_operation == OP_RESERVE);

    assign sum_lz        = low_zero(sm_rdata);
    assign sum_found     = !(&sm_rdata);
    assign scan_last     = (r_sum_idx == SUM_AW'(SUM_DEPTH - 1));
    assign scan_word_ext = (CMP_W'(r_sum_idx) << LB) | CMP_W'(sum_lz);
    assign word_lz       = low_zero(bm_rdata);
    assign frame_ext     = (CMP_W'(r_word) << LB) | CMP_W'(word_lz);
    assign clr_last      = (r_clr_cnt == WORD_AW'(WORD_CNT - 1));

    assign bit_mask  = LANE_W'(1) << r_bit;
    assign sbit_mask = LANE_W'(1) << r_sbit;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_operation == OP_ALLOC) begin
                        n_state = ST_SCAN;
                    end else if (is_upd && in_range) begin
                        n_state = ST_MODIFY;
                    end
                end
            end
            ST_SCAN: begin
                if (sum_found) begin
                    n_state = ST_WORD;
                end else if (scan_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_WORD:   n_state = ST_IDLE;
            ST_MODIFY: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_clr_cnt  = r_clr_cnt;
        n_op       = r_op;
        n_idx      = r_idx;
        n_word     = r_word;
        n_bit      = r_bit;
        n_sum_idx  = r_sum_idx;
        n_sbit     = r_sbit;
        n_sum_word = r_sum_word;
        n_done     = 1'b0;
        n_result   = r_result;
        n_status   = r_status;
        bm_we      = 1'b0;
        sm_we      = 1'b0;
        bm_waddr   = r_word;
        sm_waddr   = r_sum_idx;
        bm_raddr   = r_word;
        sm_raddr   = r_sum_idx;
        new_word   = bm_rdata | bit_mask;
        bm_wdata   = new_word;
        sm_wdata   = r_sum_word;
        unique case (r_state)
            ST_CLEAR: begin
                n_clr_cnt = r_clr_cnt + WORD_AW'(1);
                bm_we     = 1'b1;
                bm_waddr  = r_clr_cnt;
                bm_wdata  = '1;
                sm_we     = (CMP_W'(r_clr_cnt) < CMP_W'(SUM_DEPTH));
                sm_waddr  = r_clr_cnt[SUM_AW-1:0];
                sm_wdata  = '1;
            end
            ST_IDLE: begin
                bm_raddr = idx_ext[LB +: WORD_AW];
                sm_raddr = (i_operation == OP_ALLOC) ? '0 : idx_ext[2*LB +: SUM_AW];
                if (accept) begin
                    n_op      = i_operation;
                    n_idx     = i_frame_index;
                    n_word    = idx_ext[LB +: WORD_AW];
                    n_bit     = idx_ext[LB-1:0];
                    n_sum_idx = (i_operation == OP_ALLOC) ? '0 : idx_ext[2*LB +: SUM_AW];
                    n_sbit    = idx_ext[LB +: LB];
                    if ((i_operation != OP_ALLOC) && !(is_upd && in_range)) begin
                        n_done   = 1'b1;
                        n_result = i_frame_index;
                        n_status = STS_RANGE;
                    end
                end
            end
            ST_SCAN: begin
                n_sum_word = sm_rdata;
                n_sbit     = sum_lz;
                n_word     = scan_word_ext[WORD_AW-1:0];
                bm_raddr   = scan_word_ext[WORD_AW-1:0];
                if (!sum_found) begin
                    n_sum_idx = r_sum_idx + SUM_AW'(1);
                    sm_raddr  = r_sum_idx + SUM_AW'(1);
                    if (scan_last) begin
                        n_done   = 1'b1;
                        n_result = '0;
                        n_status = STS_NONE_FREE;
                    end
                end
            end
            ST_WORD: begin
                new_word = bm_rdata | (LANE_W'(1) << word_lz);
                bm_wdata = new_word;
                sm_wdata = r_sum_word | ((&new_word) ? sbit_mask : '0);
                n_done   = 1'b1;
                if (frame_ext < count_eff) begin
                    bm_we    = 1'b1;
                    sm_we    = 1'b1;
                    n_result = frame_ext[INDEX_W-1:0];
                    n_status = STS_OK;
                end else begin
                    n_result = '0;
                    n_status = STS_NONE_FREE;
                end
            end
            ST_MODIFY: begin
                new_word = (r_op == OP_RESERVE) ? (bm_rdata | bit_mask)
                                                : (bm_rdata & ~bit_mask);
                bm_wdata = new_word;
                sm_wdata = (sm_rdata & ~sbit_mask) | ((&new_word) ? sbit_mask : '0);
                bm_we    = 1'b1;
                sm_we    = 1'b1;
                n_done   = 1'b1;
                n_result = r_idx;
                n_status = STS_OK;
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr_cnt     <= '0;
            r_done        <= 1'b0;
            r_frame_count <= FRAME_COUNT_RST;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_done    <= n_done;
            if (cfg_wr && (paddr == REG_FRAME_COUNT)) begin
                r_frame_count <= pwdata[COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_idx      <= n_idx;
        r_word     <= n_word;
        r_bit      <= n_bit;
        r_sum_idx  <= n_sum_idx;
        r_sbit     <= n_sbit;
        r_sum_word <= n_sum_word;
        r_result   <= n_result;
        r_status   <= n_status;
    end

    assign o_done         = r_done;
    assign o_frame_result = r_result;
    assign o_status       = r_status;

    a_no_done_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_done)
        else $error("result strobe during clearing pass");

    a_word_has_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WORD) |-> !(&bm_rdata))
        else $error("summary pointed at a full bitmap word");

    a_update_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_upd && in_range) |=> ##1 (o_done && (o_status == STS_OK)))
        else $error("free or reserve did not complete in two cycles");

    a_scan_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_SCAN) && !sum_found && scan_last)
            |=> (o_done && (o_status == STS_NONE_FREE) && (o_frame_result == '0)))
        else $error("exhausted scan did not report no free frame");

    a_range_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_operation != OP_ALLOC) && !(is_upd && in_range))
            |=> (o_done && (o_status == STS_RANGE) && !busy))
        else $error("rejected command not reported next cycle");

endmodule
